[sv/image_convolution_3x3_replicate_edge_macros.svh]
// assertion macros for the 3x3 convolution block
// expects a clock named clk and a synchronous reset named rst in scope
`ifndef IMAGE_CONVOLUTION_3X3_REPLICATE_EDGE_MACROS_SVH
`define IMAGE_CONVOLUTION_3X3_REPLICATE_EDGE_MACROS_SVH

// same-cycle implication
`define IMCONV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define IMCONV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/imconv_pkg.sv]
// shared types, constants and helpers for the 3x3 convolution block
// no dependencies
`timescale 1ns / 1ps

package imconv_pkg;

  // line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_KERNEL_TOP   = 3'd2;
  localparam logic [2:0] REG_KERNEL_MID   = 3'd3;
  localparam logic [2:0] REG_KERNEL_BOT   = 3'd4;

  // window row select codes
  localparam logic [1:0] SEL_TOP = 2'd0;
  localparam logic [1:0] SEL_MID = 2'd1;
  localparam logic [1:0] SEL_BOT = 2'd2;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MAC  = 6'b000100,
    S_PREP = 6'b001000,
    S_DIV  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  // pixel of a packed column: top in the high byte, bottom in the low byte
  function automatic logic [7:0] pick(input logic [23:0] col, input logic [1:0] sel);
    logic [7:0] p;
    unique case (sel)
      SEL_TOP: p = col[23:16];
      SEL_MID: p = col[15:8];
      default: p = col[7:0];
    endcase
    return p;
  endfunction

endpackage

[sv/image_convolution_3x3_replicate_edge.sv]
// 3x3 normalized convolution with replicated borders, streaming top level
// depends on imconv_pkg and image_convolution_3x3_replicate_edge_macros.svh
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------
//  in      | in_valid/in_stall  | command, pixel
//  out     | out_valid/out_stall| value, out_row, out_col, last_of_frame
//  cfg     | cfg_we             | cfg_index, cfg_data
//
// one request at a time: a request without a result goes through accept and
// line store read (an ignored flush only through accept); one with a result
// goes through accept, line store read, 9 multiply-accumulate steps on one
// multiplier, divider setup, 19 steps of a bit-serial divider, output load.
// the result register lets a new request in while the last result is stalled.
// reset restores the identity kernel and a 64x64 frame; line stores are not
// cleared and need no clearing pass.
`timescale 1ns / 1ps

`include "image_convolution_3x3_replicate_edge_macros.svh"

module image_convolution_3x3_replicate_edge
  import imconv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               command,
  input  logic [7:0]         pixel,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [19:0] value,
  output logic [11:0]        out_row,
  output logic [9:0]         out_col,
  output logic               last_of_frame,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  // configuration
  logic [10:0] image_width;
  logic [11:0] image_height;
  logic [23:0] kernel_row_top, kernel_row_mid, kernel_row_bot;

  // line stores
  logic [7:0] store_one [0:MAX_WIDTH-1];
  logic [7:0] store_two [0:MAX_WIDTH-1];
  logic [7:0] rd_one, rd_two;

  // position state
  state_t      state;
  logic [12:0] in_row;
  logic [COL_W-1:0] in_col;
  logic [10:0] pending;
  logic [23:0] win [0:2];

  // current request
  logic             cur_flush;
  logic [7:0]       cur_x;
  logic [12:0]      cur_r;
  logic [COL_W-1:0] cur_c;

  // arithmetic
  logic [7:0]        tap [0:8];
  logic [4:0]        cnt;
  logic signed [19:0] acc;
  logic signed [11:0] ksum;
  logic [18:0]       quo;
  logic [10:0]       rem, dvs;
  logic              neg;
  logic [11:0]       res_row;
  logic [9:0]        res_col;
  logic              res_last;

  // effective geometry
  logic [10:0] w_eff;
  logic [11:0] h_eff;
  logic [12:0] h13;
  always_comb begin
    if (image_width == 11'd0) w_eff = 11'd1;
    else if (image_width > 11'(MAX_WIDTH)) w_eff = 11'(MAX_WIDTH);
    else w_eff = image_width;
    h_eff = (image_height == 12'd0) ? 12'd1 : image_height;
    h13   = {1'b0, h_eff};
  end

  // request start
  logic             in_take, in_go, in_restart;
  logic [COL_W-1:0] c_eff;
  logic [12:0]      r_eff;
  assign in_stall   = (state != S_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign in_go      = in_take && !(command && pending == 11'd0);
  assign in_restart = !command && pending != 11'd0;
  always_comb begin
    if (in_restart) begin
      c_eff = '0;
      r_eff = '0;
    end else begin
      c_eff = ({1'b0, in_col} >= w_eff) ? '0 : in_col;
      r_eff = in_row;
    end
  end

  // window step and emit decision
  logic [23:0] col_new, c0, c1, c2;
  logic        emit;
  logic [12:0] orow13;
  logic [9:0]  ocol;
  logic [11:0] orow;
  logic [1:0]  top_sel, bot_sel;
  logic [7:0]  tap_next [0:8];
  logic [10:0] nc;
  logic        wrap;
  logic [COL_W-1:0] col_n;
  logic [12:0] row_n;
  logic [10:0] pend_m;
  always_comb begin
    col_new = {rd_two, rd_one, cur_x};
    if (cur_c != '0) begin
      emit   = cur_r >= 13'd1 && cur_r <= h13;
      orow13 = cur_r - 13'd1;
      ocol   = 10'(cur_c - 1'b1);
      c0     = (ocol == 10'd0) ? win[2] : win[1];
      c1     = win[2];
      c2     = col_new;
    end else begin
      emit   = cur_r >= 13'd2 && cur_r <= h13 + 13'd1;
      orow13 = cur_r - 13'd2;
      ocol   = 10'(w_eff - 11'd1);
      c0     = (w_eff == 11'd1) ? win[2] : win[1];
      c1     = win[2];
      c2     = win[2];
    end
    orow    = orow13[11:0];
    top_sel = (orow == 12'd0) ? SEL_MID : SEL_TOP;
    bot_sel = (orow == h_eff - 12'd1) ? SEL_MID : SEL_BOT;
    tap_next[0] = pick(c0, top_sel);
    tap_next[1] = pick(c1, top_sel);
    tap_next[2] = pick(c2, top_sel);
    tap_next[3] = pick(c0, SEL_MID);
    tap_next[4] = pick(c1, SEL_MID);
    tap_next[5] = pick(c2, SEL_MID);
    tap_next[6] = pick(c0, bot_sel);
    tap_next[7] = pick(c1, bot_sel);
    tap_next[8] = pick(c2, bot_sel);
    nc     = {1'b0, cur_c} + 11'd1;
    wrap   = nc >= w_eff;
    col_n  = wrap ? '0 : nc[COL_W-1:0];
    if (wrap && cur_r < h13 + 13'd2) row_n = cur_r + 13'd1;
    else row_n = cur_r;
    pend_m = pending - 11'd1;
  end

  // multiply-accumulate step
  logic [71:0]        kvec;
  logic signed [7:0]  coef;
  logic signed [16:0] prod;
  assign kvec = {kernel_row_bot, kernel_row_mid, kernel_row_top};
  assign coef = kvec[{cnt[3:0], 3'b000} +: 8];
  assign prod = coef * $signed({1'b0, tap[cnt[3:0]]});

  // divider step
  logic [11:0] trial;
  logic        ge;
  assign trial = {rem, quo[18]};
  assign ge    = trial >= {1'b0, dvs};

  // line store read and write
  always_ff @(posedge clk) begin
    if (in_go) begin
      rd_one <= store_one[c_eff];
      rd_two <= store_two[c_eff];
    end
    if (state == S_READ) begin
      store_two[cur_c] <= rd_one;
      store_one[cur_c] <= cur_x;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_go) begin
      cur_flush <= command;
      cur_x     <= command ? 8'd0 : pixel;
      cur_r     <= r_eff;
      cur_c     <= c_eff;
    end
    unique case (state)
      S_READ: begin
        tap      <= tap_next;
        acc      <= '0;
        ksum     <= '0;
        res_row  <= orow;
        res_col  <= ocol;
        res_last <= (orow == h_eff - 12'd1) && ({1'b0, ocol} == w_eff - 11'd1);
      end
      S_MAC: begin
        acc  <= acc + 20'(prod);
        ksum <= ksum + 12'(coef);
      end
      S_PREP: begin
        quo <= 19'(acc[19] ? -acc : acc);
        if (ksum == 12'sd0) dvs <= 11'd1;
        else dvs <= 11'(ksum[11] ? -ksum : ksum);
        neg <= acc[19] ^ ksum[11];
        rem <= '0;
      end
      S_DIV: begin
        rem <= ge ? 11'(trial - {1'b0, dvs}) : trial[10:0];
        quo <= {quo[17:0], ge};
      end
      default: ;
    endcase
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      value         <= neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
      out_row       <= res_row;
      out_col       <= res_col;
      last_of_frame <= res_last;
    end
  end

  // control and position state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      image_width    <= 11'd64;
      image_height   <= 12'd64;
      kernel_row_top <= 24'h000000;
      kernel_row_mid <= 24'h000100;
      kernel_row_bot <= 24'h000000;
      in_row         <= '0;
      in_col         <= '0;
      pending        <= '0;
      win[0]         <= '0;
      win[1]         <= '0;
      win[2]         <= '0;
      cnt            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_go) begin
            if (in_restart) pending <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          win[0] <= win[1];
          win[1] <= win[2];
          win[2] <= col_new;
          in_col <= col_n;
          in_row <= row_n;
          if (cur_flush) begin
            if (pend_m == 11'd0) begin
              in_row  <= '0;
              in_col  <= '0;
              pending <= '0;
            end else begin
              pending <= pend_m;
            end
          end else if (row_n == h13 && col_n == '0) begin
            pending <= w_eff + 11'd1;
          end
          cnt   <= '0;
          state <= emit ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd8) state <= S_PREP;
        end
        S_PREP: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 5'd1;
          if (cnt == 5'd18) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      // configuration writes must arrive only while idle; the block itself does not enforce this
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH: begin
            image_width <= cfg_data[10:0];
            in_row      <= '0;
            in_col      <= '0;
            pending     <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            image_height <= cfg_data[11:0];
            in_row       <= '0;
            in_col       <= '0;
            pending      <= '0;
          end
          REG_KERNEL_TOP: kernel_row_top <= cfg_data;
          REG_KERNEL_MID: kernel_row_mid <= cfg_data;
          REG_KERNEL_BOT: kernel_row_bot <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // checks
  `IMCONV_ASSERT_NOW(a_pending_bound, 1'b1, pending <= w_eff + 11'd1, "pending outputs over row+1")
  `IMCONV_ASSERT_NOW(a_rem_below_div, state == S_DIV, rem < dvs, "divider remainder not below divisor")
  `IMCONV_ASSERT_NEXT(a_idle_flush, in_take && command && pending == 11'd0, state == S_IDLE, "idle flush started work")

endmodule
